>>> hw/rtl/trrt_pkg.sv
// ----------------------------------------------------------------------------
// trrt_pkg: shared types and constants for the reassembly tracker
// Request codes, sequencer states and serial-number compare helpers.
// ----------------------------------------------------------------------------
package trrt_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int BUFFER_BYTES_DEF  = 65536;
   localparam logic [31:0] SEQ_SIGN = 32'h8000_0000;
   localparam logic [15:0] WIN_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_INIT    = 2'd0,
      REQ_SEGMENT = 2'd1,
      REQ_CONSUME = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_WIN,
      ST_DONE
   } state_type;

   // serial a < b
   function automatic logic ser_lt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic logic ser_le(input logic [31:0] a, input logic [31:0] b);
      return (a == b) || ser_lt(a, b);
   endfunction

endpackage

>>> hw/rtl/trrt_ram.sv
// ----------------------------------------------------------------------------
// trrt_ram: generic single-port-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module trrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> hw/rtl/tcp_receive_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_tracker: receive sequence space of one connection
//
// req_ channel carries one request word (init, segment or consume); rsp_
// channel returns one result word per request. Both are valid/ready.
// The out-of-order interval table sits in a single RAM with a registered
// read. A non-empty segment goes to a sequencer that streams the table through
// the RAM read port once (compaction and merge, one entry a cycle, written
// back in place), then, for a segment that does not join the expected
// sequence and fits in the table, shifts entries up one at a time for
// sorted insertion, then reads the last entry for the window figure.
// One request is in flight at a time; req_ready is high only when idle.
// A finished result is held in the rsp_ registers until taken; a stalled
// receiver holds the block in the done state with the state committed.
// Reset (synchronous, active high) clears both sequences and the interval
// count; table contents are undefined until written and never read beyond
// the count.
// ----------------------------------------------------------------------------
module tcp_receive_reassembly_tracker #(
   parameter int MAX_INTERVALS = trrt_pkg::MAX_INTERVALS_DEF,
   parameter int BUFFER_BYTES  = trrt_pkg::BUFFER_BYTES_DEF,
   localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
   localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_seq_value,
   input  logic [16:0] req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_expected_seq,
   output logic [16:0] rsp_readable_bytes,
   output logic [15:0] rsp_free_window,
   output logic [4:0]  rsp_held_intervals,
   output logic [31:0] rsp_store_seq,
   output logic [16:0] rsp_store_bytes,
   output logic        rsp_interval_dropped,
   output logic [16:0] rsp_consumed_bytes
);
   localparam logic [31:0] BUF32 = 32'(BUFFER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_INTERVALS);

   trrt_pkg::state_type state_ff, state_in;
   logic [31:0] exp_ff, exp_in, base_ff, base_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] s_ff, s_in, e_ff, e_in;
   logic        direct_ff, direct_in;   // interval joins expected seq
   logic [CW-1:0] rd_ff, rd_in;        // entries issued to read
   logic [CW-1:0] ri_ff, ri_in;        // entries received
   logic [CW-1:0] w_ff, w_in;          // kept entries written
   logic [CW-1:0] j_ff, j_in;          // insertion slot
   logic        pend_ff, pend_in;      // read in flight
   logic [31:0] st_seq_ff, st_seq_in;
   logic [16:0] st_bytes_ff, st_bytes_in, cons_ff, cons_in;
   logic        drop_ff, drop_in;
   logic [15:0] win_ff, win_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   trrt_ram #(.WIDTH(64), .DEPTH(MAX_INTERVALS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trrt_pkg::ST_IDLE;
         exp_ff   <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         exp_ff   <= exp_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
      end
      s_ff <= s_in; e_ff <= e_in; direct_ff <= direct_in;
      rd_ff <= rd_in; ri_ff <= ri_in; w_ff <= w_in; j_ff <= j_in;
      pend_ff <= pend_in;
      st_seq_ff <= st_seq_in; st_bytes_ff <= st_bytes_in;
      cons_ff <= cons_in; drop_ff <= drop_in; win_ff <= win_in;
   end

   logic [31:0] seg_s, seg_e, win_end, avail, occ, is, ie, fur;
   logic [32:0] fwin;

   always_comb begin
      state_in = state_ff;
      exp_in = exp_ff; base_in = base_ff; cnt_in = cnt_ff;
      s_in = s_ff; e_in = e_ff; direct_in = direct_ff;
      rd_in = rd_ff; ri_in = ri_ff; w_in = w_ff; j_in = j_ff;
      pend_in = 1'b0;
      st_seq_in = st_seq_ff; st_bytes_in = st_bytes_ff;
      cons_in = cons_ff; drop_in = drop_ff; win_in = win_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      seg_s = req_seq_value;
      seg_e = req_seq_value + 32'(req_byte_count);
      win_end = base_ff + BUF32;
      avail = exp_ff - base_ff;
      is = rd_data[63:32];
      ie = rd_data[31:0];
      fur = exp_ff; occ = '0; fwin = '0;
      if (trrt_pkg::ser_lt(seg_s, exp_ff)) seg_s = exp_ff;
      if (trrt_pkg::ser_lt(win_end, seg_e)) seg_e = win_end;

      case (state_ff)
         trrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               st_seq_in = '0; st_bytes_in = '0; cons_in = '0; drop_in = 1'b0;
               state_in = trrt_pkg::ST_WIN;
               rd_in = '0; ri_in = '0; w_in = '0;
               case (req_type)
                  trrt_pkg::REQ_INIT: begin
                     exp_in = req_seq_value; base_in = req_seq_value; cnt_in = '0;
                  end
                  trrt_pkg::REQ_SEGMENT: begin
                     if (!trrt_pkg::ser_le(seg_e, seg_s)) begin
                        st_seq_in = seg_s;
                        st_bytes_in = 17'(seg_e - seg_s);
                        s_in = seg_s; e_in = seg_e;
                        direct_in = trrt_pkg::ser_le(seg_s, exp_ff);
                        if (trrt_pkg::ser_le(seg_s, exp_ff) &&
                            trrt_pkg::ser_lt(exp_ff, seg_e)) exp_in = seg_e;
                        state_in = trrt_pkg::ST_SCAN;
                     end
                  end
                  trrt_pkg::REQ_CONSUME: begin
                     if (avail != '0 && !avail[31]) begin
                        if (32'(req_byte_count) < avail) begin
                           cons_in = req_byte_count;
                           base_in = base_ff + 32'(req_byte_count);
                        end else begin
                           cons_in = avail[16:0];
                           base_in = exp_ff;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         trrt_pkg::ST_SCAN: begin
            // stream entries: issue read rd, process returned ri
            rd_addr = AW'(rd_ff);
            if (rd_ff < cnt_ff) begin
               rd_in = rd_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               ri_in = ri_ff + 1'b1;
               if (direct_ff) begin
                  if (trrt_pkg::ser_le(is, exp_ff)) begin
                     if (trrt_pkg::ser_lt(exp_ff, ie)) exp_in = ie;
                  end else begin
                     wr_en = 1'b1; wr_addr = AW'(w_ff); wr_data = rd_data;
                     w_in = w_ff + 1'b1;
                  end
               end else begin
                  if (trrt_pkg::ser_lt(e_ff, is) || trrt_pkg::ser_lt(ie, s_ff)) begin
                     wr_en = 1'b1; wr_addr = AW'(w_ff); wr_data = rd_data;
                     w_in = w_ff + 1'b1;
                  end else begin
                     if (trrt_pkg::ser_lt(is, s_ff)) s_in = is;
                     if (trrt_pkg::ser_lt(e_ff, ie)) e_in = ie;
                  end
               end
            end
            // writes trail reads, so in-place compaction is safe
            if (!pend_ff && rd_ff >= cnt_ff) begin
               if (direct_ff) begin
                  cnt_in = w_ff;
                  state_in = trrt_pkg::ST_WIN;
               end else if (w_ff < MAXC) begin
                  j_in = w_ff;
                  state_in = trrt_pkg::ST_INSERT;
               end else begin
                  cnt_in = w_ff; drop_in = 1'b1;
                  state_in = trrt_pkg::ST_WIN;
               end
               rd_in = '0;
            end
         end
         trrt_pkg::ST_INSERT: begin
            // read j-1, then shift or place
            rd_addr = AW'(j_ff - 1'b1);
            if (j_ff == '0) begin
               wr_en = 1'b1; wr_addr = '0; wr_data = {s_ff, e_ff};
               cnt_in = w_ff + 1'b1; state_in = trrt_pkg::ST_WIN;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
            end else if (trrt_pkg::ser_lt(s_ff, is)) begin
               wr_en = 1'b1; wr_addr = AW'(j_ff); wr_data = rd_data;
               j_in = j_ff - 1'b1;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(j_ff); wr_data = {s_ff, e_ff};
               cnt_in = w_ff + 1'b1; state_in = trrt_pkg::ST_WIN;
            end
         end
         trrt_pkg::ST_WIN: begin
            rd_addr = AW'(cnt_ff - 1'b1);
            if (cnt_ff != '0 && !pend_ff) begin
               pend_in = 1'b1;
            end else begin
               if (cnt_ff != '0) fur = ie;
               occ = fur - base_ff;
               fwin = {1'b0, BUF32} - {occ[31], occ};
               if (fwin[32]) win_in = '0;
               else if (fwin[31:16] != '0) win_in = trrt_pkg::WIN_MAX;
               else win_in = fwin[15:0];
               state_in = trrt_pkg::ST_DONE;
            end
         end
         trrt_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = trrt_pkg::ST_IDLE;
         end
         default: state_in = trrt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_next_expected_seq = exp_ff;
   assign rsp_readable_bytes    = 17'(exp_ff - base_ff);
   assign rsp_free_window       = win_ff;
   assign rsp_held_intervals    = 5'(cnt_ff);
   assign rsp_store_seq         = st_seq_ff;
   assign rsp_store_bytes       = st_bytes_ff;
   assign rsp_interval_dropped  = drop_ff;
   assign rsp_consumed_bytes    = cons_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAXC) else $error("interval count overflow");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_interval_dropped |-> cnt_ff == MAXC)
      else $error("drop without full table");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(exp_ff))
      else $error("result lost under stall");
endmodule
